>>> hw/rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and character constants for the semicolon frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

   localparam int LEN_W = 7;   // holds any counted frame length (6 + 99)

   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] PRINT_LO   = 8'h20;
   localparam logic [7:0] PRINT_HI   = 8'h7E;

   localparam logic [LEN_W-1:0] DS_LEN      = 7'd13;
   localparam logic [LEN_W-1:0] DS_PAY_END  = 7'd12;
   localparam logic [LEN_W-1:0] TB_BASE_LEN = 7'd6;
   localparam logic [LEN_W-1:0] TENS_WEIGHT = 7'd10;

   localparam logic CMD_BYTE       = 1'b0;
   localparam logic KIND_BYTE      = 1'b0;
   localparam logic KIND_ERROR     = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  frame_byte;
      logic        last;
      logic [31:0] error_total;
   } rsp_type;

   typedef struct packed {
      logic take;      // input beat accepted this cycle
      logic load;      // read buffer entry at the replay index
      logic advance;   // step replay index
      logic finish;    // frame replayed: clear fill count and replay index
      logic err_sel;   // output shows the error result
   } ctrl_cmd_type;

   typedef struct packed {
      logic emit_err;
      logic emit_frame;
      logic last_byte;
   } ctrl_status_type;

endpackage

>>> hw/rtl/semicolon_frame_parser_top.sv
// An error result shows in the cycle after its beat is taken.
// A new input beat is stalled until the error result, or the last byte of a
// frame released by a closing ';', has been accepted; each replayed byte
// takes one buffer read and then one output beat.
// Reset: synchronous; clears fill count, drop mode, error count and sequencer.
// ----------------------------------------------------------------------------
// semicolon_frame_parser_top
// Collects ';'-terminated command frames and replays them byte by byte,
// reporting parse errors with a running error total.
// ----------------------------------------------------------------------------
module semicolon_frame_parser_top
   import sfp_pkg::*;
#(
   parameter int FRAME_BYTES = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   sfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sfp_datapath #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

>>> hw/rtl/sfp_datapath.sv
// ----------------------------------------------------------------------------
// sfp_datapath
// Frame buffer, header capture, byte classification, error counter and
// replay read path.
// ----------------------------------------------------------------------------
module sfp_datapath
   import sfp_pkg::*;
#(
   parameter int FRAME_BYTES = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  req_type         req_data,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   output rsp_type         rsp_data
);

   localparam int FW = $clog2(FRAME_BYTES + 1);
   localparam int AW = $clog2(FRAME_BYTES);

   logic [7:0]    mem [FRAME_BYTES];
   logic [7:0]    rd_data_ff;
   logic [7:0]    hdr0_ff, hdr1_ff, hdr3_ff, hdr4_ff;
   logic [FW-1:0] fill_ff, fill_in;
   logic          drop_ff, drop_in;
   logic [31:0]   err_cnt_ff, err_cnt_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;

   logic [LEN_W-1:0] fill_ext, fill_p1, want;
   logic             is_ds, is_tb, full, printable, ds_body, is_semi;
   logic             dec_err, dec_frame, dec_store, dec_drop, dec_clear;
   logic             wr_en;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   assign fill_ext = LEN_W'(fill_ff);
   assign fill_p1  = fill_ext + LEN_W'(1);
   assign full     = fill_ff >= FW'(FRAME_BYTES);
   assign is_semi  = req_data.rx_byte == CHAR_SEMI;

   assign is_ds = (fill_ff >= FW'(2)) && (hdr0_ff == CHAR_D) && (hdr1_ff == CHAR_S);
   assign is_tb = (fill_ff >= FW'(5)) && (hdr0_ff == CHAR_T) && (hdr1_ff == CHAR_B)
                  && is_digit(hdr3_ff) && is_digit(hdr4_ff);

   always_comb begin
      if (is_ds) begin
         want = DS_LEN;
      end else if (is_tb) begin
         want = TB_BASE_LEN + LEN_W'(hdr3_ff[3:0]) * TENS_WEIGHT + LEN_W'(hdr4_ff[3:0]);
      end else begin
         want = '0;
      end
   end

   assign printable = (req_data.rx_byte >= PRINT_LO) && (req_data.rx_byte <= PRINT_HI);
   assign ds_body   = is_ds && (fill_ext < DS_PAY_END);

   // outcome of the current input beat; applied only when it is taken
   always_comb begin
      dec_err   = 1'b0;
      dec_frame = 1'b0;
      dec_store = 1'b0;
      dec_drop  = drop_ff;
      dec_clear = 1'b0;
      if (req_data.cmd != CMD_BYTE) begin
         dec_err   = (fill_ff != '0) || drop_ff;
         dec_drop  = 1'b0;
         dec_clear = 1'b1;
      end else if (is_semi) begin
         if (drop_ff) begin
            dec_drop  = 1'b0;
            dec_clear = 1'b1;
         end else if (fill_ff == '0) begin
            dec_err   = 1'b1;
            dec_clear = 1'b1;
         end else if ((want != '0) && (fill_p1 < want)) begin
            // embedded semicolon inside a counted frame
            if (full) begin
               dec_err   = 1'b1;
               dec_drop  = 1'b1;
               dec_clear = 1'b1;
            end else begin
               dec_store = 1'b1;
            end
         end else if (((want != '0) && (fill_p1 != want)) || full) begin
            dec_err   = 1'b1;
            dec_clear = 1'b1;
         end else begin
            dec_store = 1'b1;
            dec_frame = 1'b1;
         end
      end else if (!drop_ff) begin
         if ((!printable && !ds_body) || (fill_p1 >= LEN_W'(FRAME_BYTES))) begin
            dec_err   = 1'b1;
            dec_drop  = 1'b1;
            dec_clear = 1'b1;
         end else begin
            dec_store = 1'b1;
         end
      end
   end

   assign wr_en = cmd.take && dec_store;

   always_comb begin
      fill_in    = fill_ff;
      drop_in    = drop_ff;
      err_cnt_in = err_cnt_ff;
      rd_idx_in  = rd_idx_ff;
      if (cmd.take) begin
         drop_in = dec_drop;
         if (dec_clear) begin
            fill_in = '0;
         end else if (dec_store) begin
            fill_in = fill_ff + FW'(1);
         end
         if (dec_err) begin
            err_cnt_in = err_cnt_ff + 32'd1;
         end
      end
      if (cmd.advance) begin
         rd_idx_in = rd_idx_ff + AW'(1);
      end
      if (cmd.finish) begin
         rd_idx_in = '0;
         fill_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         drop_ff    <= 1'b0;
         err_cnt_ff <= '0;
         rd_idx_ff  <= '0;
      end else begin
         fill_ff    <= fill_in;
         drop_ff    <= drop_in;
         err_cnt_ff <= err_cnt_in;
         rd_idx_ff  <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff[AW-1:0]] <= req_data.rx_byte;
      end
      if (cmd.load) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   // header bytes kept beside the buffer for length decoding
   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (fill_ff == FW'(0)) hdr0_ff <= req_data.rx_byte;
         if (fill_ff == FW'(1)) hdr1_ff <= req_data.rx_byte;
         if (fill_ff == FW'(3)) hdr3_ff <= req_data.rx_byte;
         if (fill_ff == FW'(4)) hdr4_ff <= req_data.rx_byte;
      end
   end

   assign status.emit_err   = dec_err;
   assign status.emit_frame = dec_frame;
   assign status.last_byte  = (FW'(rd_idx_ff) + FW'(1)) == fill_ff;

   always_comb begin
      rsp_data.error_total = err_cnt_ff;
      if (cmd.err_sel) begin
         rsp_data.kind       = KIND_ERROR;
         rsp_data.frame_byte = '0;
         rsp_data.last       = 1'b1;
      end else begin
         rsp_data.kind       = KIND_BYTE;
         rsp_data.frame_byte = rd_data_ff;
         rsp_data.last       = status.last_byte;
      end
   end

endmodule

>>> hw/rtl/sfp_ctrl.sv
// ----------------------------------------------------------------------------
// sfp_ctrl
// Sequencer: takes one input beat; if it ends in an error or completes a frame,
// shows the error result or replays the frame, one buffer read per byte.
// ----------------------------------------------------------------------------
module sfp_ctrl
   import sfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ERR  = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_SHOW = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = (state_ff == ST_ERR) || (state_ff == ST_SHOW);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.err_sel = state_ff == ST_ERR;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.emit_err) begin
                  state_in = ST_ERR;
               end else if (status.emit_frame) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_ERR: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.load = 1'b1;
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (!rsp_stall) begin
               if (status.last_byte) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> verif/tb_semicolon_frame_parser_top.sv
// ----------------------------------------------------------------------------
// tb_semicolon_frame_parser_top
// Self-checking bench for the semicolon frame parser. Drives byte and
// disconnect beats in random bursts and mirrors the parser in a scoreboard
// that predicts every replayed frame byte and error beat. The directed part
// covers the basic error paths. The random part covers plain, DS and TB
// frames, broken frames, noise and full-buffer frames. The result channel
// stalls on its own pattern and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_semicolon_frame_parser_top;
   import sfp_pkg::*;

   localparam int FRAME_BYTES  = 64;
   localparam int CLK_HALF     = 6;
   localparam int ITEM_TARGET  = 230;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 120;
   localparam int DRAIN_CYCLES = 160;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int MAX_REPORTS  = 10;

   localparam logic CMD_LINK_DROP = 1'b1;

   // Mirror of the parser: frame buffer, fill level, drop flag, error count
   class frame_scoreboard;
      logic [7:0]  store [FRAME_BYTES];
      int unsigned fill;
      bit          dropping;
      logic [31:0] err_count;
      rsp_type     due_beats [$];
      int unsigned mismatches;

      function new();
         fill       = 0;
         dropping   = 1'b0;
         err_count  = '0;
         mismatches = 0;
      endfunction

      function void raise_error(bit drop_after);
         rsp_type r;
         fill        = 0;
         dropping    = drop_after;
         err_count   = err_count + 32'd1;
         r.kind        = KIND_ERROR;
         r.frame_byte  = 8'h00;
         r.last        = 1'b1;
         r.error_total = err_count;
         due_beats.push_back(r);
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CHAR_ZERO && c <= CHAR_NINE;
      endfunction

      function bit ds_frame();
         return fill >= 2 && store[0] == CHAR_D && store[1] == CHAR_S;
      endfunction

      // Expected total length of a counted frame, zero when not counted
      function int unsigned frame_length();
         int unsigned tens;
         int unsigned ones;
         if (ds_frame())
            return int'(DS_LEN);
         if (fill >= 5 && store[0] == CHAR_T && store[1] == CHAR_B &&
             is_digit(store[3]) && is_digit(store[4])) begin
            tens = int'(store[3]) - int'(CHAR_ZERO);
            ones = int'(store[4]) - int'(CHAR_ZERO);
            return int'(TB_BASE_LEN) + tens * int'(TENS_WEIGHT) + ones;
         end
         return 0;
      endfunction

      function void parse_beat(req_type d);
         int unsigned want;
         bit          printable;
         bit          ds_body;
         rsp_type     r;
         if (d.cmd != CMD_BYTE) begin
            if (fill != 0 || dropping)
               raise_error(1'b0);
            fill     = 0;
            dropping = 1'b0;
            return;
         end
         if (d.rx_byte == CHAR_SEMI) begin
            if (dropping) begin
               dropping = 1'b0;
               fill     = 0;
               return;
            end
            if (fill == 0) begin
               raise_error(1'b0);
               return;
            end
            want = frame_length();
            // counted frame still short: ';' is data
            if (want != 0 && fill + 1 < want) begin
               if (fill >= FRAME_BYTES) begin
                  raise_error(1'b1);
               end else begin
                  store[fill] = CHAR_SEMI;
                  fill++;
               end
               return;
            end
            if ((want != 0 && fill + 1 != want) || fill >= FRAME_BYTES) begin
               raise_error(1'b0);
               return;
            end
            store[fill] = CHAR_SEMI;
            fill++;
            for (int unsigned k = 0; k < fill; k++) begin
               r.kind        = KIND_BYTE;
               r.frame_byte  = store[k];
               r.last        = (k + 1 == fill);
               r.error_total = err_count;
               due_beats.push_back(r);
            end
            fill = 0;
            return;
         end
         if (dropping)
            return;
         printable = d.rx_byte >= PRINT_LO && d.rx_byte <= PRINT_HI;
         ds_body   = ds_frame() && fill < int'(DS_PAY_END);
         if ((!printable && !ds_body) || fill + 1 >= FRAME_BYTES) begin
            raise_error(1'b1);
         end else begin
            store[fill] = d.rx_byte;
            fill++;
         end
      endfunction

      function void report(string what, rsp_type exp, rsp_type got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%s: exp k=%0d b=%h l=%0d t=%0d, got k=%0d b=%h l=%0d t=%0d",
                     what, exp.kind, exp.frame_byte, exp.last, exp.error_total,
                     got.kind, got.frame_byte, got.last, got.error_total);
      endfunction

      function void match_beat(rsp_type got);
         rsp_type exp;
         if (due_beats.size() == 0) begin
            report("unexpected beat", '0, got);
            return;
         end
         exp = due_beats.pop_front();
         if (got.kind !== exp.kind || got.frame_byte !== exp.frame_byte ||
             got.last !== exp.last || got.error_total !== exp.error_total)
            report("beat mismatch", exp, got);
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   frame_scoreboard sb;
   int unsigned     items_sent;
   int unsigned     beats_taken;
   int unsigned     burst_left;
   bit              long_hold_done;

   semicolon_frame_parser_top #(
      .FRAME_BYTES(FRAME_BYTES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   // Input beats are noted before results so a same-edge result finds its entry
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            sb.parse_beat(req_data);
            beats_taken++;
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.match_beat(rsp_data);
      end
   end

   // Result side: stall pattern picked anew for each random-length span, one long hold
   initial begin
      int unsigned mode;
      int unsigned span;
      int unsigned tick;
      rsp_stall      = 1'b0;
      long_hold_done = 1'b0;
      tick           = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 80);
         repeat (span) begin
            @(negedge clock);
            tick++;
            if (!long_hold_done && beats_taken >= HOLD_AFTER) begin
               long_hold_done = 1'b1;
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES - 1) @(negedge clock);
            end else begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= ((tick % 5) < 2);
               endcase
            end
         end
      end
   end

   task automatic send_item(logic cmd_bit, logic [7:0] b);
      req_type     d;
      int unsigned gap;
      d.cmd     = cmd_bit;
      d.rx_byte = b;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
   endtask

   task automatic send_byte(logic [7:0] b);
      send_item(CMD_BYTE, b);
   endtask

   task automatic send_link_drop();
      send_item(CMD_LINK_DROP, 8'($urandom_range(0, 255)));
   endtask

   function automatic logic [7:0] rand_text();
      logic [7:0] b;
      do b = 8'($urandom_range(PRINT_LO, PRINT_HI)); while (b == CHAR_SEMI);
      return b;
   endfunction

   function automatic logic [7:0] rand_unprintable();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b >= PRINT_LO && b <= PRINT_HI);
      return b;
   endfunction

   // "TB", a tag char, two length chars, then body bytes with some ';' mixed in
   task automatic send_tb_head(logic [7:0] tens, logic [7:0] ones, int body_len);
      send_byte(CHAR_T);
      send_byte(CHAR_B);
      send_byte(rand_text());
      send_byte(tens);
      send_byte(ones);
      for (int i = 0; i < body_len; i++)
         send_byte(($urandom_range(0, 4) == 0) ? CHAR_SEMI : rand_text());
   endtask

   // Frames that run the buffer to its end
   task automatic send_full_frame(int variant);
      case (variant)
         0: begin   // 64-byte frame, the longest replay
            send_tb_head(CHAR_ZERO + 8'd5, CHAR_ZERO + 8'd8, 58);
            send_byte(CHAR_SEMI);
         end
         1: begin   // closing ';' finds the buffer full
            send_tb_head(CHAR_ZERO + 8'd5, CHAR_ZERO + 8'd9, 58);
            send_byte(CHAR_SEMI);
            send_byte(CHAR_SEMI);
         end
         2: begin   // embedded ';' with the buffer full
            send_tb_head(CHAR_NINE, CHAR_NINE, 58);
            send_byte(CHAR_SEMI);
            send_byte(CHAR_SEMI);
            send_byte(CHAR_SEMI);
         end
         default: begin   // text byte into the last free slot
            send_tb_head(CHAR_NINE, CHAR_NINE, 58);
            send_byte(rand_text());
            send_byte(CHAR_SEMI);
         end
      endcase
   endtask

   task automatic send_random_sequence();
      int unsigned len;
      int unsigned nn;
      int unsigned variant;
      int unsigned bad_at;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            len    = $urandom_range(1, 12);
            bad_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : len;
            for (int unsigned i = 0; i < len; i++)
               send_byte((i == bad_at) ? rand_unprintable() : rand_text());
            send_byte(CHAR_SEMI);
         end
         3, 4: begin
            send_byte(CHAR_D);
            send_byte(CHAR_S);
            repeat (10) send_byte(8'($urandom_range(0, 255)));
            variant = $urandom_range(0, 5);
            if (variant == 0)
               send_byte(rand_text());          // one byte too long
            else if (variant == 1)
               send_byte(rand_unprintable());   // binary past the payload
            send_byte(CHAR_SEMI);
         end
         5, 6: begin
            nn      = $urandom_range(0, 12);
            variant = $urandom_range(0, 5);
            case (variant)
               0: send_tb_head(CHAR_ZERO + 8'(nn / 10), CHAR_ZERO + 8'(nn % 10), nn + 1);
               1: send_tb_head(CHAR_ZERO + 8'(nn / 10), CHAR_ZERO + 8'(nn % 10),
                               (nn == 0) ? 0 : nn - 1);
               2: send_tb_head(CHAR_ZERO + 8'(nn / 10), rand_text(), nn);
               default: send_tb_head(CHAR_ZERO + 8'(nn / 10), CHAR_ZERO + 8'(nn % 10), nn);
            endcase
            send_byte(CHAR_SEMI);
         end
         7: begin
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 2) == 0)
                  send_link_drop();
               else
                  send_byte(8'($urandom_range(0, 255)));
            end
         end
         8: begin
            repeat ($urandom_range(1, 6)) send_byte(rand_text());
            send_link_drop();
         end
         default: send_byte(CHAR_SEMI);
      endcase
   endtask

   initial begin
      int unsigned seq_count;
      int unsigned full_next;
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      items_sent  = 0;
      beats_taken = 0;
      burst_left  = 0;
      seq_count   = 0;
      full_next   = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_byte(CHAR_SEMI);                          // empty frame
      send_byte("A");
      send_byte(CHAR_SEMI);
      send_byte(PRINT_LO);
      send_byte(PRINT_HI);
      send_byte(CHAR_SEMI);
      send_byte(8'h1F);                              // bad byte, then dropped
      send_byte("Z");
      send_byte(CHAR_SEMI);                          // leaves drop mode
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(CHAR_SEMI);
      send_link_drop();                              // nothing pending
      send_byte("Q");
      send_link_drop();                              // partial frame
      send_byte(8'h7F);
      send_link_drop();                              // while dropping
      send_byte(CHAR_T);                             // TB00 with one extra byte
      send_byte(CHAR_B);
      send_byte("x");
      send_byte(CHAR_ZERO);
      send_byte(CHAR_ZERO);
      send_byte("y");
      send_byte(CHAR_SEMI);

      while (items_sent < ITEM_TARGET) begin
         if (seq_count % 6 == 5 && full_next < 4) begin
            send_full_frame(full_next);
            full_next++;
         end else begin
            send_random_sequence();
         end
         seq_count++;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.due_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_beats.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/sfp_pkg.sv
hw/rtl/sfp_datapath.sv
hw/rtl/sfp_ctrl.sv
hw/rtl/semicolon_frame_parser_top.sv
verif/tb_semicolon_frame_parser_top.sv
